// ===== rtl/core/sbsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single-button strip dimmer package
// Shared constants and register indexes for the dimmer core.
// ----------------------------------------------------------------------------
package sbsd_pkg;

  localparam int STRIPS = 2;
  localparam int SIDX_W = (STRIPS > 1) ? $clog2(STRIPS) : 1;

  localparam logic [7:0] HALF_LEVEL = 8'd128;
  localparam logic [7:0] START_LEVEL = 8'd150;
  localparam logic [31:0] ENTRY_GRACE_MS = 32'd100;

  // Configuration register indexes
  localparam logic [2:0] REG_DEBOUNCE = 3'd0;
  localparam logic [2:0] REG_SHORT = 3'd1;
  localparam logic [2:0] REG_LONG = 3'd2;
  localparam logic [2:0] REG_IDLE = 3'd3;
  localparam logic [2:0] REG_IND_PERIOD = 3'd4;
  localparam logic [2:0] REG_RAMP_TIME = 3'd5;
  localparam logic [2:0] REG_MIN_LEVEL = 3'd6;
  localparam logic [2:0] REG_MAX_LEVEL = 3'd7;

  // Press machine codes
  localparam logic [1:0] PS_IDLE = 2'd0;
  localparam logic [1:0] PS_PRESSED = 2'd1;
  localparam logic [1:0] PS_HELD = 2'd2;
  localparam logic [1:0] PS_RELEASED = 2'd3;

endpackage

// ===== rtl/core/single_button_strip_dimmer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single-button strip dimmer core
// Debounces one button sample per tick, runs the press and control-mode
// logic, ramps the marked strip and sends one result per strip.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents
// in_     | slave     | tdata[0] button_level
// out_    | master    | tdata strip fields, tlast on the final strip
// cfg_    | write     | we, 3-bit index, 16-bit data
//
// Each tick passes through control states (transfer, press machine, timeout and
// ramp setup), then, when a ramp runs, through the multiply and shift-subtract
// divider (one multiply, 24 divide steps, one level update), then sends one
// strip result per transfer. A zero ramp time skips the divide steps.
// The divider is the one multi-step arithmetic unit.
// Reset is synchronous, active low, and clears the control state and configuration to power-up values;
// the divider operands and quotient are not reset. Output stalls simply hold the block; no input is taken
// until all results of a tick have been transferred.
// ----------------------------------------------------------------------------
module single_button_strip_dimmer_core import sbsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] button_level
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [2:0] strip_index, [3] lit, [11:4] level,
                                  // [12] indicator_on, [14:13] indicator_color,
                                  // [15] in_control_mode
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRESS, ST_RAMP, ST_DIV, ST_FIN, ST_EMIT
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [15:0] deb_r, short_r, long_r, idle_r, indp_r, rampt_r;
  logic [7:0]  minl_r, maxl_r;

  // Tick state
  logic [31:0] now_r, lchg_r, pstart_r, lact_r, mentry_r, rstart_r;
  logic        raw_prev_r, stable_r, ctrl_r, markv_r, ramp_r;
  logic [1:0]  ps_r;
  logic [SIDX_W-1:0] mark_r;
  logic [7:0]  rlevel_r;
  logic [STRIPS-1:0] on_r, marked_r, up_r;
  logic [7:0]  lvl_r [STRIPS];
  logic [1:0]  col_r [STRIPS];
  logic [31:0] indms_r [STRIPS];

  // Divider registers: quotient of mag * elapsed / rampt_r, formed in quo_r
  logic [23:0] quo_r;
  logic [15:0] rem_r;
  logic [4:0]  dcnt_r;
  logic [7:0]  endl_r;
  logic        endge_r, rampend_r;
  logic [SIDX_W-1:0] eidx_r;

  logic [31:0] t;
  assign t = now_r;

  // Combinational helpers
  logic [SIDX_W-1:0] next_mark;
  logic [SIDX_W-1:0] pick;
  logic [31:0] dur, el;
  logic [7:0]  mag8;
  logic [16:0] rem_sh;
  logic [7:0]  nl;
  logic        show;

  always_comb begin
    next_mark = (markv_r && (32'(mark_r) + 32'd1 < 32'(STRIPS))) ?
                SIDX_W'(32'(mark_r) + 32'd1) : '0;
    if (!markv_r) next_mark = '0;
    pick = '0;
    for (int i = STRIPS - 1; i >= 0; i--) begin
      if (on_r[i]) pick = SIDX_W'(i);
    end
    dur = t - pstart_r;
    el = t - rstart_r;
    if (el >= {16'd0, rampt_r}) el = {16'd0, rampt_r};
    rem_sh = {rem_r, quo_r[23]};
    nl = endge_r ? (rlevel_r + quo_r[7:0]) : (rlevel_r - quo_r[7:0]);
    mag8 = endge_r ? (endl_r - rlevel_r) : (rlevel_r - endl_r);
    show = marked_r[eidx_r] && ctrl_r && !ramp_r;
  end

  // Sequencer and all state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      deb_r <= 16'd50; short_r <= 16'd200; long_r <= 16'd1000;
      idle_r <= 16'd3000; indp_r <= 16'd500; rampt_r <= 16'd5000;
      minl_r <= 8'd10; maxl_r <= 8'd255;
      now_r <= '0; lchg_r <= '0; pstart_r <= '0; lact_r <= '0;
      mentry_r <= '0; rstart_r <= '0;
      raw_prev_r <= 1'b1; stable_r <= 1'b1; ps_r <= PS_IDLE;
      ctrl_r <= 1'b0; markv_r <= 1'b0; mark_r <= '0; ramp_r <= 1'b0;
      rlevel_r <= '0; on_r <= '0; marked_r <= '0; up_r <= '0;
      for (int i = 0; i < STRIPS; i++) begin
        lvl_r[i] <= START_LEVEL; col_r[i] <= '0; indms_r[i] <= '0;
      end
      eidx_r <= '0; dcnt_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE:   deb_r <= cfg_data;
          REG_SHORT:      short_r <= cfg_data;
          REG_LONG:       long_r <= cfg_data;
          REG_IDLE:       idle_r <= cfg_data;
          REG_IND_PERIOD: indp_r <= cfg_data;
          REG_RAMP_TIME:  rampt_r <= cfg_data;
          REG_MIN_LEVEL:  minl_r <= cfg_data[7:0];
          REG_MAX_LEVEL:  maxl_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          // Debounce on transfer of the button sample.
          if (in_tvalid) begin
            raw_prev_r <= in_tdata[0];
            if (in_tdata[0] != raw_prev_r) begin
              lchg_r <= t;
              if (deb_r == 16'd0) stable_r <= in_tdata[0];
            end else if (t - lchg_r >= {16'd0, deb_r}) begin
              stable_r <= in_tdata[0];
            end
            state_r <= ST_PRESS;
          end
        end
        ST_PRESS: begin
          // Press machine, then the idle timeout check.
          case (ps_r)
            PS_IDLE: begin
              if (!stable_r) begin
                ps_r <= PS_PRESSED; pstart_r <= t; lact_r <= t;
              end
            end
            PS_PRESSED: begin
              if (!stable_r) begin
                if (dur >= {16'd0, long_r}) begin
                  ps_r <= PS_HELD;
                  if (!ctrl_r) begin
                    ctrl_r <= 1'b1; mentry_r <= t;
                    for (int i = 0; i < STRIPS; i++) col_r[i] <= '0;
                    marked_r <= STRIPS'(1) << pick; indms_r[pick] <= t;
                    if (!on_r[pick]) begin
                      on_r[pick] <= 1'b1; lvl_r[pick] <= HALF_LEVEL;
                    end
                    markv_r <= 1'b1; mark_r <= pick;
                  end
                end
              end else begin
                if (dur < {16'd0, long_r}) begin
                  if (dur < {16'd0, short_r}) begin
                    if (ctrl_r) begin
                      for (int i = 0; i < STRIPS; i++) col_r[i] <= '0;
                      marked_r <= STRIPS'(1) << next_mark;
                      indms_r[next_mark] <= t;
                      if (!on_r[next_mark]) begin
                        on_r[next_mark] <= 1'b1; lvl_r[next_mark] <= HALF_LEVEL;
                      end
                      markv_r <= 1'b1; mark_r <= next_mark;
                    end
                  end else if (!ctrl_r) begin
                    if (|on_r) begin
                      on_r <= '0; marked_r <= '0; markv_r <= 1'b0;
                    end else begin
                      on_r <= '1;
                      for (int i = 0; i < STRIPS; i++) lvl_r[i] <= HALF_LEVEL;
                    end
                  end
                end
                ps_r <= PS_IDLE; lact_r <= t;
              end
            end
            PS_HELD: begin
              if (stable_r) begin
                ps_r <= PS_RELEASED; lact_r <= t; ramp_r <= 1'b0;
              end else if (ctrl_r && markv_r && !ramp_r &&
                           (t - mentry_r > ENTRY_GRACE_MS)) begin
                up_r[mark_r] <= 1'b0; rstart_r <= t;
                rlevel_r <= lvl_r[mark_r]; ramp_r <= 1'b1;
              end
            end
            default: begin
              if (!stable_r) begin
                ps_r <= PS_HELD; pstart_r <= t; lact_r <= t;
                if (ctrl_r && markv_r) begin
                  up_r[mark_r] <= !up_r[mark_r]; rstart_r <= t;
                  rlevel_r <= lvl_r[mark_r]; ramp_r <= 1'b1;
                end
              end else begin
                ps_r <= PS_IDLE; ramp_r <= 1'b0;
              end
            end
          endcase
          state_r <= ST_RAMP;
        end
        ST_RAMP: begin
          // Idle timeout uses the updated activity time.
          if (ctrl_r && (t - lact_r >= {16'd0, idle_r})) begin
            ctrl_r <= 1'b0; mentry_r <= '0; ramp_r <= 1'b0;
            if (markv_r) begin
              marked_r[mark_r] <= 1'b0; col_r[mark_r] <= '0;
            end
            markv_r <= 1'b0;
            state_r <= ST_EMIT; eidx_r <= '0;
          end else if (ramp_r && markv_r) begin
            if (ps_r != PS_HELD) begin
              ramp_r <= 1'b0; state_r <= ST_EMIT; eidx_r <= '0;
            end else begin
              endl_r <= up_r[mark_r] ? maxl_r : minl_r;
              endge_r <= (up_r[mark_r] ? maxl_r : minl_r) >= rlevel_r;
              rampend_r <= (t - rstart_r) >= {16'd0, rampt_r};
              quo_r <= {8'd0, el[15:0]};
              rem_r <= '0; dcnt_r <= '0;
              state_r <= ST_DIV;
            end
          end else begin
            state_r <= ST_EMIT; eidx_r <= '0;
          end
        end
        ST_DIV: begin
          // First step forms mag*e, or mag alone at zero ramp time; later steps restore-divide by ramp time.
          if (dcnt_r == 5'd0) begin
            if (rampt_r == 16'd0) begin
              quo_r <= {16'd0, mag8}; state_r <= ST_FIN;
            end else begin
              quo_r <= 24'(mag8) * 24'(quo_r[15:0]);
              dcnt_r <= 5'd1;
            end
          end else begin
            if (rem_sh >= {1'b0, rampt_r}) begin
              rem_r <= 16'(rem_sh - {1'b0, rampt_r}); quo_r <= {quo_r[22:0], 1'b1};
            end else begin
              rem_r <= rem_sh[15:0]; quo_r <= {quo_r[22:0], 1'b0};
            end
            dcnt_r <= dcnt_r + 5'd1;
            if (dcnt_r == 5'd24) state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (up_r[mark_r] && nl >= maxl_r) begin
            lvl_r[mark_r] <= maxl_r; ramp_r <= 1'b0;
          end else if (!up_r[mark_r] && nl <= minl_r) begin
            lvl_r[mark_r] <= minl_r; ramp_r <= 1'b0;
          end else begin
            lvl_r[mark_r] <= nl;
            if (rampend_r) ramp_r <= 1'b0;
          end
          state_r <= ST_EMIT; eidx_r <= '0;
        end
        ST_EMIT: begin
          // Indicator step is applied on the transfer of each strip result.
          if (out_tready) begin
            if (show && (t - indms_r[eidx_r] >= {16'd0, indp_r})) begin
              col_r[eidx_r] <= (col_r[eidx_r] == 2'd2) ? 2'd0 : col_r[eidx_r] + 2'd1;
              indms_r[eidx_r] <= t;
            end
            if (32'(eidx_r) == 32'(STRIPS - 1)) begin
              now_r <= t + 32'd1; state_r <= ST_IDLE;
            end else begin
              eidx_r <= eidx_r + SIDX_W'(1);
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Result formatting
  logic [1:0] col_now;
  always_comb begin
    col_now = col_r[eidx_r];
    if (show && (t - indms_r[eidx_r] >= {16'd0, indp_r}))
      col_now = (col_r[eidx_r] == 2'd2) ? 2'd0 : col_r[eidx_r] + 2'd1;
  end

  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tlast = (32'(eidx_r) == 32'(STRIPS - 1));
  assign out_tdata = {ctrl_r, show ? col_now : 2'd0, show, lvl_r[eidx_r],
                      on_r[eidx_r], 3'(eidx_r)};

  // Checks
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input and output both open");
  a_mark_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    markv_r |-> ctrl_r)
    else $error("strip marked outside control mode");
  a_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (now_r == $past(now_r) + 32'd1))
    else $error("tick not advanced");

endmodule
